FILE: design/mcd_pkg.sv
`timescale 1ns / 1ps

package mcd_pkg;

  // request actions
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_STARTED  = 3'd0;
  localparam logic [2:0] KIND_CARVED   = 3'd1;
  localparam logic [2:0] KIND_FINISHED = 3'd2;
  localparam logic [2:0] KIND_WALL     = 3'd3;
  localparam logic [2:0] KIND_BAD      = 3'd4;

  // directions, also the wall bit index of a cell
  localparam logic [1:0] DIR_DN = 2'd0;
  localparam logic [1:0] DIR_RT = 2'd1;
  localparam logic [1:0] DIR_UP = 2'd2;
  localparam logic [1:0] DIR_LT = 2'd3;

  // cell entry: visited bit over four wall bits
  localparam int          VISITED_BIT = 4;
  localparam logic [4:0]  ALL_WALLS   = 5'b0_1111;

  localparam logic [4:0]  ORDER_COUNT = 5'd24;
  localparam logic [2:0]  TRIES_DONE  = 3'd4;

  // try order for each lexicographic order index, first try leftmost
  localparam logic [0:3][1:0] PERM_TABLE [24] = '{
    {DIR_DN, DIR_RT, DIR_UP, DIR_LT}, {DIR_DN, DIR_RT, DIR_LT, DIR_UP},
    {DIR_DN, DIR_UP, DIR_RT, DIR_LT}, {DIR_DN, DIR_UP, DIR_LT, DIR_RT},
    {DIR_DN, DIR_LT, DIR_RT, DIR_UP}, {DIR_DN, DIR_LT, DIR_UP, DIR_RT},
    {DIR_RT, DIR_DN, DIR_UP, DIR_LT}, {DIR_RT, DIR_DN, DIR_LT, DIR_UP},
    {DIR_RT, DIR_UP, DIR_DN, DIR_LT}, {DIR_RT, DIR_UP, DIR_LT, DIR_DN},
    {DIR_RT, DIR_LT, DIR_DN, DIR_UP}, {DIR_RT, DIR_LT, DIR_UP, DIR_DN},
    {DIR_UP, DIR_DN, DIR_RT, DIR_LT}, {DIR_UP, DIR_DN, DIR_LT, DIR_RT},
    {DIR_UP, DIR_RT, DIR_DN, DIR_LT}, {DIR_UP, DIR_RT, DIR_LT, DIR_DN},
    {DIR_UP, DIR_LT, DIR_DN, DIR_RT}, {DIR_UP, DIR_LT, DIR_RT, DIR_DN},
    {DIR_LT, DIR_DN, DIR_RT, DIR_UP}, {DIR_LT, DIR_DN, DIR_UP, DIR_RT},
    {DIR_LT, DIR_RT, DIR_DN, DIR_UP}, {DIR_LT, DIR_RT, DIR_UP, DIR_DN},
    {DIR_LT, DIR_UP, DIR_DN, DIR_RT}, {DIR_LT, DIR_UP, DIR_RT, DIR_DN}
  };

endpackage

FILE: design/maze_carver_dfs.sv
`timescale 1ns / 1ps

// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+----------------------------------
// request   | in        | start & !busy               | action, row, col, order, side
// result    | out       | result_valid_o (one cycle)  | kind, cell_row, cell_col,
//           |           |                             | direction, wall_present
// config    | in        | apb write, pready always 1  | grid_rows @0x0, grid_cols @0x4
//
// read wall: a cell memory read in S_RDWALL; bad coordinates or advance on an empty stack:
// answered from idle. advance: S_TRY once per try, a neighbor probe through a cell
// memory read (S_CHECK), a popped frame via a stack memory read (S_POP), carving in S_CARVE.
// start: one cell memory entry cleared per cycle in S_CLEAR, start cell marked visited.
// after reset the same clearing pass runs with busy high.
// results are registered and shown for one cycle; the receiver cannot stall.

module maze_carver_dfs #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [4:0]  row_i,
  input  logic [4:0]  col_i,
  input  logic [4:0]  order_i,
  input  logic [1:0]  side_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [4:0]  cell_row_o,
  output logic [4:0]  cell_col_o,
  output logic [1:0]  direction_o,
  output logic        wall_present_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDWALL = 3'd2;
  localparam logic [2:0] S_TRY    = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_CARVE  = 3'd6;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [CW-1:0] c;
    logic [4:0]    ord;
    logic [2:0]    tried;
  } frame_t;

  function automatic logic [AW-1:0] cell_idx(logic [RW-1:0] r, logic [CW-1:0] c);
    cell_idx = AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
  endfunction

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          pend_q, pend_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [5:0]    grid_rows_q, grid_cols_q;
  frame_t        top_q, top_d;
  logic [4:0]    ordin_q, ordin_d;
  logic [RW-1:0] nbr_q, nbr_d;
  logic [CW-1:0] nbc_q, nbc_d;
  logic [1:0]    dir_q, dir_d;
  logic [1:0]    side_q, side_d;

  logic          valid_q, valid_d;
  logic [2:0]    kind_q, kind_d;
  logic [4:0]    orow_q, orow_d, ocol_q, ocol_d;
  logic [1:0]    odir_q, odir_d;
  logic          owall_q, owall_d;

  // cell memory: {visited, walls}
  logic [4:0]    cell_mem [CELLS];
  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [4:0]    cell_wdata, cell_rdata_q;

  // frames below the top of stack; the top frame lives in top_q
  frame_t        stk_mem [CELLS];
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  frame_t        stk_wdata, stk_rdata_q;

  logic [5:0]    rows_eff, cols_eff;
  logic [4:0]    ord_wrap;
  logic          bad_cell;
  logic [1:0]    try_dir;
  logic          try_ok;
  logic [RW-1:0] try_r;
  logic [CW-1:0] try_c;
  logic [8:0]    r_ext, c_ext;
  logic          cfg_wr;

  always_comb begin
    if (grid_rows_q == 6'd0) begin
      rows_eff = 6'd1;
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows_eff = 6'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_q;
    end
    if (grid_cols_q == 6'd0) begin
      cols_eff = 6'd1;
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_eff = 6'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_q;
    end
  end

  assign ord_wrap = (order_i >= mcd_pkg::ORDER_COUNT) ? 5'(order_i - mcd_pkg::ORDER_COUNT)
                                                       : order_i;
  assign bad_cell = ({1'b0, row_i} >= rows_eff) || ({1'b0, col_i} >= cols_eff);

  // neighbor for the next try of the top frame
  assign r_ext   = 9'(top_q.r);
  assign c_ext   = 9'(top_q.c);
  assign try_dir = mcd_pkg::PERM_TABLE[top_q.ord][top_q.tried[1:0]];

  always_comb begin
    try_r  = top_q.r;
    try_c  = top_q.c;
    try_ok = 1'b0;
    case (try_dir)
      mcd_pkg::DIR_DN: begin
        try_ok = (r_ext + 9'd1) < 9'(rows_eff);
        try_r  = RW'(r_ext + 9'd1);
      end
      mcd_pkg::DIR_RT: begin
        try_ok = (c_ext + 9'd1) < 9'(cols_eff);
        try_c  = CW'(c_ext + 9'd1);
      end
      mcd_pkg::DIR_UP: begin
        try_ok = r_ext != 9'd0;
        try_r  = RW'(r_ext - 9'd1);
      end
      default: begin
        try_ok = c_ext != 9'd0;
        try_c  = CW'(c_ext - 9'd1);
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pend_d     = pend_q;
    depth_d    = depth_q;
    top_d      = top_q;
    ordin_d    = ordin_q;
    nbr_d      = nbr_q;
    nbc_d      = nbc_q;
    dir_d      = dir_q;
    side_d     = side_q;
    valid_d    = 1'b0;
    kind_d     = mcd_pkg::KIND_STARTED;
    orow_d     = 5'd0;
    ocol_d     = 5'd0;
    odir_d     = 2'd0;
    owall_d    = 1'b0;
    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = mcd_pkg::ALL_WALLS;
    cell_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = top_q;
    stk_raddr  = '0;

    unique case (state_q)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        if (pend_q && (clr_q == cell_idx(top_q.r, top_q.c))) begin
          cell_wdata = mcd_pkg::ALL_WALLS | 5'(1 << mcd_pkg::VISITED_BIT);
        end
        if (clr_q == AW'(CELLS - 1)) begin
          clr_d   = '0;
          state_d = S_IDLE;
          if (pend_q) begin
            pend_d  = 1'b0;
            valid_d = 1'b1;
            kind_d  = mcd_pkg::KIND_STARTED;
            orow_d  = 5'(top_q.r);
            ocol_d  = 5'(top_q.c);
          end
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (action_i)
            mcd_pkg::ACT_START, mcd_pkg::ACT_READ: begin
              if (bad_cell) begin
                valid_d = 1'b1;
                kind_d  = mcd_pkg::KIND_BAD;
              end else if (action_i == mcd_pkg::ACT_READ) begin
                cell_raddr = cell_idx(RW'(row_i), CW'(col_i));
                side_d     = side_i;
                state_d    = S_RDWALL;
              end else begin
                top_d   = '{r: RW'(row_i), c: CW'(col_i), ord: ord_wrap, tried: 3'd0};
                depth_d = DW'(1);
                pend_d  = 1'b1;
                state_d = S_CLEAR;
              end
            end
            mcd_pkg::ACT_ADVANCE: begin
              if (depth_q == '0) begin
                valid_d = 1'b1;
                kind_d  = mcd_pkg::KIND_FINISHED;
              end else begin
                ordin_d = ord_wrap;
                state_d = S_TRY;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDWALL: begin
        valid_d = 1'b1;
        kind_d  = mcd_pkg::KIND_WALL;
        owall_d = cell_rdata_q[side_q];
        state_d = S_IDLE;
      end
      S_TRY: begin
        if (top_q.tried == mcd_pkg::TRIES_DONE) begin
          depth_d = depth_q - DW'(1);
          if (depth_q == DW'(1)) begin
            valid_d = 1'b1;
            kind_d  = mcd_pkg::KIND_FINISHED;
            state_d = S_IDLE;
          end else begin
            stk_raddr = AW'(depth_q - DW'(2));
            state_d   = S_POP;
          end
        end else begin
          top_d.tried = top_q.tried + 3'd1;
          dir_d       = try_dir;
          nbr_d       = try_r;
          nbc_d       = try_c;
          if (try_ok) begin
            cell_raddr = cell_idx(try_r, try_c);
            state_d    = S_CHECK;
          end
        end
      end
      S_POP: begin
        top_d   = stk_rdata_q;
        state_d = S_TRY;
      end
      S_CHECK: begin
        if (cell_rdata_q[mcd_pkg::VISITED_BIT]) begin
          state_d = S_TRY;
        end else begin
          // enter the neighbor: drop its wall facing back, mark visited
          cell_we    = 1'b1;
          cell_waddr = cell_idx(nbr_q, nbc_q);
          cell_wdata = (cell_rdata_q & ~5'(5'd1 << (dir_q + 2'd2)))
                     | 5'(1 << mcd_pkg::VISITED_BIT);
          cell_raddr = cell_idx(top_q.r, top_q.c);
          state_d    = S_CARVE;
        end
      end
      S_CARVE: begin
        cell_we    = 1'b1;
        cell_waddr = cell_idx(top_q.r, top_q.c);
        cell_wdata = cell_rdata_q & ~5'(5'd1 << dir_q);
        if (depth_q < DW'(CELLS)) begin
          stk_we    = 1'b1;
          stk_waddr = AW'(depth_q - DW'(1));
          top_d     = '{r: nbr_q, c: nbc_q, ord: ordin_q, tried: 3'd0};
          depth_d   = depth_q + DW'(1);
        end
        valid_d = 1'b1;
        kind_d  = mcd_pkg::KIND_CARVED;
        orow_d  = 5'(nbr_q);
        ocol_d  = 5'(nbc_q);
        odir_d  = dir_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      depth_q     <= '0;
      valid_q     <= 1'b0;
      grid_rows_q <= 6'd32;
      grid_cols_q <= 6'd32;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      depth_q <= depth_d;
      valid_q <= valid_d;
      if (cfg_wr && !paddr[2]) begin
        grid_rows_q <= pwdata[5:0];
      end
      if (cfg_wr && paddr[2]) begin
        grid_cols_q <= pwdata[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    ordin_q <= ordin_d;
    nbr_q   <= nbr_d;
    nbc_q   <= nbc_d;
    dir_q   <= dir_d;
    side_q  <= side_d;
    kind_q  <= kind_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    odir_q  <= odir_d;
    owall_q <= owall_d;
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = valid_q;
  assign kind_o         = kind_q;
  assign cell_row_o     = orow_q;
  assign cell_col_o     = ocol_q;
  assign direction_o    = odir_q;
  assign wall_present_o = owall_q;
  assign pready         = 1'b1;
  assign prdata         = paddr[2] ? {26'd0, grid_cols_q} : {26'd0, grid_rows_q};

endmodule

FILE: design/mcd_checker.sv
`timescale 1ns / 1ps

module mcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] action_i,
  input logic       result_valid_o,
  input logic [2:0] kind_o,
  input logic [4:0] cell_row_o,
  input logic [4:0] cell_col_o,
  input logic [1:0] direction_o,
  input logic       wall_present_o
);

  // results only appear once the carver is back to taking requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // an unknown action is dropped without a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == mcd_pkg::ACT_NONE) |=> !result_valid_o)
    else $error("result for an ignored request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o != mcd_pkg::KIND_WALL) |-> !wall_present_o)
    else $error("wall bit outside a wall read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == mcd_pkg::KIND_BAD || kind_o == mcd_pkg::KIND_FINISHED))
      |-> (cell_row_o == 5'd0 && cell_col_o == 5'd0 && direction_o == 2'd0))
    else $error("payload not cleared");

endmodule

bind maze_carver_dfs mcd_checker u_mcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .action_i       (action_i),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .cell_row_o     (cell_row_o),
  .cell_col_o     (cell_col_o),
  .direction_o    (direction_o),
  .wall_present_o (wall_present_o)
);

FILE: bench/tb_maze_carver_dfs.sv
`timescale 1ns / 1ps

module tb_maze_carver_dfs;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam logic [2:0] ADDR_ROWS = 3'd0;
  localparam logic [2:0] ADDR_COLS = 3'd4;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  // a finishing advance may pop every frame of a full grid
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] row;
    logic [4:0] col;
    logic [1:0] dir;
    logic       wall;
  } carve_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = mcd_pkg::ACT_NONE;
  logic [4:0]  row_i = '0;
  logic [4:0]  col_i = '0;
  logic [4:0]  order_i = '0;
  logic [1:0]  side_i = '0;
  logic        result_valid_o;
  logic [2:0]  kind_o;
  logic [4:0]  cell_row_o;
  logic [4:0]  cell_col_o;
  logic [1:0]  direction_o;
  logic        wall_present_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  maze_carver_dfs #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .action_i(action_i),
    .row_i(row_i),
    .col_i(col_i),
    .order_i(order_i),
    .side_i(side_i),
    .result_valid_o(result_valid_o),
    .kind_o(kind_o),
    .cell_row_o(cell_row_o),
    .cell_col_o(cell_col_o),
    .direction_o(direction_o),
    .wall_present_o(wall_present_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the maze: bounds, cells and the backtrack path
  logic [5:0]    rows_reg = 6'd32;
  logic [5:0]    cols_reg = 6'd32;
  logic [4:0]    maze_cells [CELL_COUNT];
  logic [4:0]    path_row [CELL_COUNT];
  logic [4:0]    path_col [CELL_COUNT];
  logic [4:0]    path_order [CELL_COUNT];
  logic [2:0]    path_tried [CELL_COUNT];
  int            path_depth = 0;
  carve_result_t due_results [$];
  logic [2:0]    last_kind = mcd_pkg::KIND_STARTED;
  int            failures = 0;
  int            work_items = 0;
  int            stall_cycles = 0;
  bit            gaps_on = 1'b1;

  initial begin
    foreach (maze_cells[i]) maze_cells[i] = mcd_pkg::ALL_WALLS;
  end

  function automatic int eff_span(logic [5:0] v);
    if (v == 6'd0) return 1;
    if (v > 6'd32) return 32;
    return int'(v);
  endfunction

  function automatic void predict_carve_step(input logic [1:0] act, input logic [4:0] r_in,
                                             input logic [4:0] c_in, input logic [4:0] ord_in,
                                             input logic [1:0] side_in);
    carve_result_t res;
    int rows, cols, top, r, c, nr, nc;
    logic [1:0] d;
    logic [4:0] ord;
    bit ok;
    res = '0;
    rows = eff_span(rows_reg);
    cols = eff_span(cols_reg);
    ord = (ord_in >= mcd_pkg::ORDER_COUNT) ? 5'(ord_in - mcd_pkg::ORDER_COUNT) : ord_in;
    if (act == mcd_pkg::ACT_NONE) return;
    if (act == mcd_pkg::ACT_START || act == mcd_pkg::ACT_READ) begin
      if (int'(r_in) >= rows || int'(c_in) >= cols) begin
        res.kind = mcd_pkg::KIND_BAD;
      end else if (act == mcd_pkg::ACT_READ) begin
        res.kind = mcd_pkg::KIND_WALL;
        res.wall = maze_cells[int'(r_in) * MAX_COLS + int'(c_in)][side_in];
      end else begin
        foreach (maze_cells[i]) maze_cells[i] = mcd_pkg::ALL_WALLS;
        maze_cells[int'(r_in) * MAX_COLS + int'(c_in)][mcd_pkg::VISITED_BIT] = 1'b1;
        path_row[0] = r_in;
        path_col[0] = c_in;
        path_order[0] = ord;
        path_tried[0] = '0;
        path_depth = 1;
        res.kind = mcd_pkg::KIND_STARTED;
        res.row = r_in;
        res.col = c_in;
      end
      due_results.push_back(res);
      last_kind = res.kind;
      return;
    end
    while (path_depth > 0) begin
      top = path_depth - 1;
      while (path_tried[top] < mcd_pkg::TRIES_DONE) begin
        d = mcd_pkg::PERM_TABLE[path_order[top]][path_tried[top][1:0]];
        path_tried[top] = path_tried[top] + 3'd1;
        r = int'(path_row[top]);
        c = int'(path_col[top]);
        nr = r;
        nc = c;
        case (d)
          mcd_pkg::DIR_DN: begin ok = (r + 1 < rows); nr = r + 1; end
          mcd_pkg::DIR_RT: begin ok = (c + 1 < cols); nc = c + 1; end
          mcd_pkg::DIR_UP: begin ok = (r >= 1); nr = r - 1; end
          default: begin ok = (c >= 1); nc = c - 1; end
        endcase
        if (ok) begin
          if (!maze_cells[nr * MAX_COLS + nc][mcd_pkg::VISITED_BIT]) begin
            maze_cells[r * MAX_COLS + c][d] = 1'b0;
            maze_cells[nr * MAX_COLS + nc][2'(d + 2'd2)] = 1'b0;
            maze_cells[nr * MAX_COLS + nc][mcd_pkg::VISITED_BIT] = 1'b1;
            if (path_depth < CELL_COUNT) begin
              path_row[path_depth] = 5'(nr);
              path_col[path_depth] = 5'(nc);
              path_order[path_depth] = ord;
              path_tried[path_depth] = '0;
              path_depth++;
            end
            res.kind = mcd_pkg::KIND_CARVED;
            res.row = 5'(nr);
            res.col = 5'(nc);
            res.dir = d;
            due_results.push_back(res);
            last_kind = res.kind;
            return;
          end
        end
      end
      path_depth--;
    end
    res.kind = mcd_pkg::KIND_FINISHED;
    due_results.push_back(res);
    last_kind = res.kind;
  endfunction

  // start stays high from one accepted request into the next one, unless gaps are on and a random gap drops it first
  task automatic send_request(input logic [1:0] act, input logic [4:0] r, input logic [4:0] c,
                              input logic [4:0] ord, input logic [1:0] side);
    while (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    row_i <= r;
    col_i <= c;
    order_i <= ord;
    side_i <= side;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_carve_step(act, r, c, ord, side);
    if (act != mcd_pkg::ACT_NONE) work_items++;
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    // an ignored request may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [5:0] value);
    wait_quiet();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {26'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ROWS) rows_reg = value;
    else cols_reg = value;
  endtask

  function automatic logic [5:0] pick_span();
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 10) begin
      case ($urandom_range(5))
        0: return 6'd0;
        1: return 6'd1;
        2: return 6'd2;
        3: return 6'd32;
        4: return 6'd33;
        default: return 6'd63;
      endcase
    end
    if (pick < 20) return 6'($urandom_range(9, 32));
    return 6'($urandom_range(1, 8));
  endfunction

  task automatic test_idle_grid();
    send_request(mcd_pkg::ACT_READ, 5'd0, 5'd0, 5'd0, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_READ, 5'd31, 5'd31, 5'd31, mcd_pkg::DIR_LT);
    send_request(mcd_pkg::ACT_READ, 5'd31, 5'd0, 5'd17, mcd_pkg::DIR_RT);
    send_request(mcd_pkg::ACT_READ, 5'd0, 5'd31, 5'd8, mcd_pkg::DIR_UP);
    // nothing on the path stack yet
    send_request(mcd_pkg::ACT_ADVANCE, 5'd31, 5'd31, 5'd31, mcd_pkg::DIR_LT);
    send_request(mcd_pkg::ACT_NONE, 5'd31, 5'd31, 5'd31, mcd_pkg::DIR_LT);
  endtask

  task automatic test_bound_clamp();
    write_reg(ADDR_ROWS, 6'd0);
    write_reg(ADDR_COLS, 6'd3);
    send_request(mcd_pkg::ACT_START, 5'd1, 5'd0, 5'd0, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_START, 5'd0, 5'd3, 5'd0, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_READ, 5'd0, 5'd3, 5'd0, mcd_pkg::DIR_RT);
    send_request(mcd_pkg::ACT_START, 5'd0, 5'd1, 5'd24, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_ADVANCE, 5'd0, 5'd0, 5'd0, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_ADVANCE, 5'd0, 5'd0, 5'd23, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_ADVANCE, 5'd0, 5'd0, 5'd5, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_READ, 5'd0, 5'd1, 5'd0, mcd_pkg::DIR_RT);
    write_reg(ADDR_ROWS, 6'd63);
    write_reg(ADDR_COLS, 6'd63);
    send_request(mcd_pkg::ACT_READ, 5'd31, 5'd31, 5'd0, mcd_pkg::DIR_UP);
  endtask

  task automatic test_shrink_mid_carve();
    write_reg(ADDR_ROWS, 6'd32);
    write_reg(ADDR_COLS, 6'd32);
    send_request(mcd_pkg::ACT_START, 5'd31, 5'd31, 5'd23, mcd_pkg::DIR_DN);
    send_request(mcd_pkg::ACT_ADVANCE, 5'd0, 5'd0, 5'd0, mcd_pkg::DIR_DN);
    // frames already on the path keep their cells, neighbor tests see new bounds
    write_reg(ADDR_ROWS, 6'd1);
    write_reg(ADDR_COLS, 6'd31);
    repeat (3) send_request(mcd_pkg::ACT_ADVANCE, 5'd0, 5'd0, 5'd12, mcd_pkg::DIR_DN);
  endtask

  task automatic test_random_mazes();
    int base, phase, budget, pick, rows, cols;
    bit done;
    base = work_items;
    phase = 0;
    while (work_items - base < RANDOM_ITEMS) begin
      gaps_on = !(phase >= 8 && phase < 14);
      write_reg(ADDR_ROWS, pick_span());
      write_reg(ADDR_COLS, pick_span());
      rows = eff_span(rows_reg);
      cols = eff_span(cols_reg);
      if (!(path_depth > 0 && $urandom_range(99) < 30)) begin
        if ($urandom_range(99) < 15)
          send_request(mcd_pkg::ACT_START, 5'($urandom), 5'($urandom), 5'($urandom),
                       2'($urandom));
        send_request(mcd_pkg::ACT_START, 5'($urandom_range(rows - 1)),
                     5'($urandom_range(cols - 1)), 5'($urandom_range(31)), 2'($urandom));
      end
      budget = 300;
      done = 1'b0;
      while (!done && budget > 0) begin
        budget--;
        pick = int'($urandom_range(99));
        if (pick < 66) begin
          send_request(mcd_pkg::ACT_ADVANCE, 5'($urandom), 5'($urandom),
                       5'($urandom_range(31)), 2'($urandom));
          if (last_kind == mcd_pkg::KIND_FINISHED) done = ($urandom_range(3) != 0);
        end else if (pick < 80) begin
          send_request(mcd_pkg::ACT_READ, 5'($urandom_range(rows - 1)),
                       5'($urandom_range(cols - 1)), 5'($urandom), 2'($urandom));
        end else if (pick < 86) begin
          send_request(mcd_pkg::ACT_READ, 5'($urandom), 5'($urandom), 5'($urandom),
                       2'($urandom));
        end else if (pick < 90) begin
          send_request(mcd_pkg::ACT_NONE, 5'($urandom), 5'($urandom), 5'($urandom),
                       2'($urandom));
        end else if (pick < 94) begin
          send_request(mcd_pkg::ACT_START, 5'($urandom), 5'($urandom), 5'($urandom),
                       2'($urandom));
        end else begin
          send_request(mcd_pkg::ACT_START, 5'($urandom_range(rows - 1)),
                       5'($urandom_range(cols - 1)), 5'($urandom), 2'($urandom));
        end
      end
      phase++;
    end
  endtask

  always @(posedge clk_i) begin : check_result
    carve_result_t want;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d", kind_o);
        failures++;
      end else begin
        want = due_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          failures++;
        end
        if (cell_row_o !== want.row) begin
          $error("cell_row: expected %0d, got %0d", want.row, cell_row_o);
          failures++;
        end
        if (cell_col_o !== want.col) begin
          $error("cell_col: expected %0d, got %0d", want.col, cell_col_o);
          failures++;
        end
        if (direction_o !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, direction_o);
          failures++;
        end
        if (wall_present_o !== want.wall) begin
          $error("wall_present: expected %0d, got %0d", want.wall, wall_present_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || result_valid_o === 1'b1 ||
        (psel && penable && pwrite && pready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("maze_carver_dfs regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_grid();
    test_bound_clamp();
    test_shrink_mid_carve();
    test_random_mazes();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("maze_carver_dfs regression: pass");
    end else begin
      $display("maze_carver_dfs regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mcd_pkg.sv
design/maze_carver_dfs.sv
design/mcd_checker.sv
bench/tb_maze_carver_dfs.sv
